>>> rtl/core/hc22_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc22_pkg
// types, register indexes and mod 26 helpers shared by the hill cipher core
// ----------------------------------------------------------------------------
package hc22_pkg;

    localparam int unsigned LETTER_W = 5;
    localparam int unsigned PROD_W   = 10;
    localparam int unsigned WIDE_W   = 11;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 5;

    typedef logic [LETTER_W-1:0] letter_t;
    typedef logic [PROD_W-1:0]   prod_t;
    typedef logic [WIDE_W-1:0]   wide_t;

    // register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_C  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd4;

    localparam letter_t MODULUS = 5'd26;
    localparam wide_t   MOD_SQ  = 11'd676;

    typedef struct packed {
        letter_t first_letter;
        letter_t second_letter;
        logic    second_present;
    } in_item_t;

    typedef struct packed {
        letter_t out_first;
        letter_t out_second;
        logic    key_error;
    } out_item_t;

    // one classified pair waiting for the back end
    typedef struct packed {
        letter_t p0;
        letter_t p1;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // effective matrix used by the back end
    typedef struct packed {
        letter_t m0;
        letter_t m1;
        letter_t m2;
        letter_t m3;
        logic    err;
    } key_t;

    // reduce a 5 bit code mod 26
    function automatic letter_t mod26_letter(input letter_t x);
        letter_t r;
        r = (x >= MODULUS) ? letter_t'(x - MODULUS) : x;
        return r;
    endfunction

    // reduce an 11 bit value mod 26: reciprocal multiply, exact below 2048
    function automatic letter_t mod26_wide(input wide_t x);
        logic [22:0] prod;
        logic [6:0]  q;
        wide_t       qm;
        wide_t       r;
        prod = {12'd0, x} * 23'd2521;
        q    = prod[22:16];
        qm   = {4'd0, q} * 11'd26;
        r    = x - qm;
        return r[LETTER_W-1:0];
    endfunction

    // additive inverse mod 26 of a reduced code
    function automatic letter_t neg26(input letter_t x);
        letter_t r;
        r = (x == 5'd0) ? 5'd0 : letter_t'(MODULUS - x);
        return r;
    endfunction

    // multiplicative inverse mod 26, zero when none exists
    function automatic letter_t inv26(input letter_t x);
        letter_t r;
        unique case (x)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/hill_cipher_2x2_mod26_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26_top
// 2x2 hill cipher core, while busy is low encrypts or decrypts one letter pair per cycle
// ----------------------------------------------------------------------------
//
// channel   | handshake                     | payload
// ----------+-------------------------------+---------------------------------
// command   | start in, busy out            | item (first/second letter, flag)
// result    | done strobe, one cycle        | result (two letters, key_error)
// config    | cfg_valid in, cfg_ready out   | cfg_index, cfg_data
//
// one pair is taken per cycle while busy is low; its result strobes on done after
// the queue, product and mod 26 reduce registers; busy stays high after reset
// and after every config write while the key inversion pipeline (products,
// determinant inverse, adjugate) settles; the result side cannot stall, so
// the queue drains every cycle and busy otherwise only rises if the queue
// ever fills
//
module hill_cipher_2x2_mod26_top
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // command transaction
    input  logic                                start,
    input  hc22_pkg::in_item_t                  item,
    output logic                                busy,
    // result transaction
    output hc22_pkg::out_item_t                 result,
    output logic                                done,
    // configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hc22_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hc22_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // front to queue
    logic                push;
    hc22_pkg::q_entry_t  push_entry;
    // queue to back end
    hc22_pkg::q_entry_t  head;
    hc22_pkg::q_status_t q_status;
    logic                pop;
    // effective key matrix, stable while items are in flight
    hc22_pkg::key_t      key;

    // intake, config registers and key inversion
    hc22_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .busy       (busy),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry),
        .key        (key)
    );

    // decoupling queue
    hc22_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // matrix multiply mod 26
    hc22_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .key      (key),
        .pop      (pop),
        .result   (result),
        .done     (done)
    );

`ifndef ASSERT_OFF
    // every letter leaving the core is a proper code
    a_letters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.out_first < 5'd26) && (result.out_second < 5'd26))
        else $error("result letter out of range");

    // an unusable key gives zero letters
    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.key_error |-> (result.out_first == 5'd0) && (result.out_second == 5'd0))
        else $error("key error with nonzero letters");

    // no command is taken while the key pipeline settles
    a_busy_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> busy)
        else $error("command window open right after config write");
`endif

endmodule

>>> rtl/core/hc22_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc22_front
// config registers, key inversion pipeline and command intake
// ----------------------------------------------------------------------------
module hc22_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  hc22_pkg::in_item_t                  item,
    output logic                                busy,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hc22_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hc22_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  hc22_pkg::q_status_t                 q_status,
    output logic                                push,
    output hc22_pkg::q_entry_t                  push_entry,
    output hc22_pkg::key_t                      key
);

    localparam logic [1:0] SETTLE = 2'd3;

    hc22_pkg::letter_t key_a_reg, key_b_reg, key_c_reg, key_d_reg;
    logic              mode_reg;
    hc22_pkg::prod_t   ad_reg, bc_reg;
    hc22_pkg::letter_t dinv_reg;
    logic              err_reg;
    hc22_pkg::key_t    key_reg, key_next;
    logic [1:0]        settle_reg;
    hc22_pkg::letter_t det;
    logic              cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg  <= 5'd1;
            key_b_reg  <= 5'd0;
            key_c_reg  <= 5'd0;
            key_d_reg  <= 5'd1;
            mode_reg   <= 1'b0;
            settle_reg <= SETTLE;
        end
        else
        begin
            if (cfg_wr)
            begin
                settle_reg <= SETTLE;
                unique case (cfg_index)
                    hc22_pkg::CFG_KEY_A: key_a_reg <= hc22_pkg::mod26_letter(cfg_data);
                    hc22_pkg::CFG_KEY_B: key_b_reg <= hc22_pkg::mod26_letter(cfg_data);
                    hc22_pkg::CFG_KEY_C: key_c_reg <= hc22_pkg::mod26_letter(cfg_data);
                    hc22_pkg::CFG_KEY_D: key_d_reg <= hc22_pkg::mod26_letter(cfg_data);
                    hc22_pkg::CFG_MODE:  mode_reg  <= cfg_data[0];
                    default:             ;
                endcase
            end
            else if (settle_reg != 2'd0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    // determinant products
    always_ff @(posedge clk)
    begin
        ad_reg <= hc22_pkg::prod_t'(key_a_reg) * hc22_pkg::prod_t'(key_d_reg);
        bc_reg <= hc22_pkg::prod_t'(key_b_reg) * hc22_pkg::prod_t'(key_c_reg);
    end

    // determinant and its inverse
    assign det = hc22_pkg::mod26_wide({1'b0, ad_reg} + hc22_pkg::MOD_SQ - {1'b0, bc_reg});

    always_ff @(posedge clk)
    begin
        dinv_reg <= hc22_pkg::inv26(det);
        err_reg  <= (hc22_pkg::inv26(det) == 5'd0);
    end

    // scaled adjugate in decrypt mode, key as is otherwise
    always_comb
    begin
        key_next.err = err_reg;
        if (mode_reg)
        begin
            key_next.m0 = hc22_pkg::mod26_wide(
                hc22_pkg::wide_t'(key_d_reg) * hc22_pkg::wide_t'(dinv_reg));
            key_next.m1 = hc22_pkg::mod26_wide(
                hc22_pkg::wide_t'(hc22_pkg::neg26(key_b_reg)) * hc22_pkg::wide_t'(dinv_reg));
            key_next.m2 = hc22_pkg::mod26_wide(
                hc22_pkg::wide_t'(hc22_pkg::neg26(key_c_reg)) * hc22_pkg::wide_t'(dinv_reg));
            key_next.m3 = hc22_pkg::mod26_wide(
                hc22_pkg::wide_t'(key_a_reg) * hc22_pkg::wide_t'(dinv_reg));
        end
        else
        begin
            key_next.m0 = key_a_reg;
            key_next.m1 = key_b_reg;
            key_next.m2 = key_c_reg;
            key_next.m3 = key_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key  = key_reg;
    assign busy = (settle_reg != 2'd0) || q_status.full;
    assign push = start && !busy;

    // reduce letters, pad a missing second letter
    assign push_entry.p0 = hc22_pkg::mod26_letter(item.first_letter);
    assign push_entry.p1 = item.second_present ?
                           hc22_pkg::mod26_letter(item.second_letter) : 5'd0;

endmodule

>>> rtl/core/hc22_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc22_queue
// short fifo between intake and the arithmetic back end
// ----------------------------------------------------------------------------
module hc22_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hc22_pkg::q_entry_t   push_entry,
    input  logic                 pop,
    output hc22_pkg::q_entry_t   head,
    output hc22_pkg::q_status_t  status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    hc22_pkg::q_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign status.empty = (count_reg == CNT_W'(0));
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full && !pop |=> count_reg == CNT_W'(DEPTH))
        else $error("queue count moved past full");
`endif

endmodule

>>> rtl/core/hc22_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hc22_back
// two stage matrix multiply mod 26 with registered result
// ----------------------------------------------------------------------------
module hc22_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hc22_pkg::q_status_t  q_status,
    input  hc22_pkg::q_entry_t   head,
    input  hc22_pkg::key_t       key,
    output logic                 pop,
    output hc22_pkg::out_item_t  result,
    output logic                 done
);

    hc22_pkg::prod_t     pr0_reg, pr1_reg, pr2_reg, pr3_reg;
    logic                err_reg;
    logic                s1_valid_reg;
    hc22_pkg::out_item_t result_reg, result_next;
    logic                done_reg;

    // output never stalls, so drain one entry every cycle while the queue is not empty
    assign pop = !q_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pop;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pr0_reg <= hc22_pkg::prod_t'(key.m0) * hc22_pkg::prod_t'(head.p0);
        pr1_reg <= hc22_pkg::prod_t'(key.m1) * hc22_pkg::prod_t'(head.p1);
        pr2_reg <= hc22_pkg::prod_t'(key.m2) * hc22_pkg::prod_t'(head.p0);
        pr3_reg <= hc22_pkg::prod_t'(key.m3) * hc22_pkg::prod_t'(head.p1);
        err_reg <= key.err;
    end

    always_comb
    begin
        result_next.key_error = err_reg;
        if (err_reg)
        begin
            result_next.out_first  = 5'd0;
            result_next.out_second = 5'd0;
        end
        else
        begin
            result_next.out_first  = hc22_pkg::mod26_wide({1'b0, pr0_reg} + {1'b0, pr1_reg});
            result_next.out_second = hc22_pkg::mod26_wide({1'b0, pr2_reg} + {1'b0, pr3_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

>>> test/hill_pair_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hill_pair_checker
// watches the command, result and config channels of the 2x2 hill cipher
// core, predicts each result letter pair and compares it on arrival
// ----------------------------------------------------------------------------
module hill_pair_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  hc22_pkg::in_item_t              item,
    input  logic                            busy,
    input  hc22_pkg::out_item_t             result,
    input  logic                            done,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [hc22_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hc22_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                     fail_count,
    output int unsigned                     pending_count,
    output int unsigned                     results_checked
);

    localparam int unsigned LETTER_COUNT = 26;

    // shadow copy of the key registers
    hc22_pkg::letter_t key_a_q;
    hc22_pkg::letter_t key_b_q;
    hc22_pkg::letter_t key_c_q;
    hc22_pkg::letter_t key_d_q;
    logic              decrypt_q;

    hc22_pkg::out_item_t pending_letter_pairs[$];
    int unsigned         mismatches;
    int unsigned         compared;

    function automatic hc22_pkg::out_item_t cipher_letter_pair(input hc22_pkg::in_item_t pair);
        int unsigned a, b, c, d;
        int unsigned p0, p1;
        int unsigned det, det_inv, t;
        int unsigned m0, m1, m2, m3;
        hc22_pkg::out_item_t r;
        a  = key_a_q % LETTER_COUNT;
        b  = key_b_q % LETTER_COUNT;
        c  = key_c_q % LETTER_COUNT;
        d  = key_d_q % LETTER_COUNT;
        p0 = pair.first_letter % LETTER_COUNT;
        p1 = pair.second_present ? pair.second_letter % LETTER_COUNT : 0;
        det = (a * d + LETTER_COUNT * LETTER_COUNT - b * c) % LETTER_COUNT;
        det_inv = 0;
        for (t = 1; t < LETTER_COUNT; t++)
        begin
            if (det_inv == 0 && (det * t) % LETTER_COUNT == 1)
                det_inv = t;
        end
        if (det_inv == 0)
        begin
            r.out_first  = '0;
            r.out_second = '0;
            r.key_error  = 1'b1;
            return r;
        end
        if (decrypt_q)
        begin
            // adjugate scaled by the determinant inverse
            m0 = (d * det_inv) % LETTER_COUNT;
            m1 = (((LETTER_COUNT - b) % LETTER_COUNT) * det_inv) % LETTER_COUNT;
            m2 = (((LETTER_COUNT - c) % LETTER_COUNT) * det_inv) % LETTER_COUNT;
            m3 = (a * det_inv) % LETTER_COUNT;
        end
        else
        begin
            m0 = a;
            m1 = b;
            m2 = c;
            m3 = d;
        end
        r.out_first  = hc22_pkg::letter_t'((m0 * p0 + m1 * p1) % LETTER_COUNT);
        r.out_second = hc22_pkg::letter_t'((m2 * p0 + m3 * p1) % LETTER_COUNT);
        r.key_error  = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hc22_pkg::out_item_t want;
        if (!rst_n)
        begin
            key_a_q     = 5'd1;
            key_b_q     = 5'd0;
            key_c_q     = 5'd0;
            key_d_q     = 5'd1;
            decrypt_q   = 1'b0;
            pending_letter_pairs.delete();
            mismatches  = 0;
            compared    = 0;
            fail_count      <= 0;
            pending_count   <= 0;
            results_checked <= 0;
        end
        else
        begin
            // result side first, a new command cannot finish in the same cycle
            if (done)
            begin
                if (pending_letter_pairs.size() == 0)
                begin
                    $error("result with no pending pair: out_first %0d out_second %0d key_error %0d",
                           result.out_first, result.out_second, result.key_error);
                    mismatches++;
                end
                else
                begin
                    want = pending_letter_pairs.pop_front();
                    compared++;
                    if (result.out_first !== want.out_first)
                    begin
                        $error("out_first: expected %0d, actual %0d",
                               want.out_first, result.out_first);
                        mismatches++;
                    end
                    if (result.out_second !== want.out_second)
                    begin
                        $error("out_second: expected %0d, actual %0d",
                               want.out_second, result.out_second);
                        mismatches++;
                    end
                    if (result.key_error !== want.key_error)
                    begin
                        $error("key_error: expected %0d, actual %0d",
                               want.key_error, result.key_error);
                        mismatches++;
                    end
                end
            end

            if (start && !busy)
                pending_letter_pairs.push_back(cipher_letter_pair(item));

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    hc22_pkg::CFG_KEY_A: key_a_q   = cfg_data;
                    hc22_pkg::CFG_KEY_B: key_b_q   = cfg_data;
                    hc22_pkg::CFG_KEY_C: key_c_q   = cfg_data;
                    hc22_pkg::CFG_KEY_D: key_d_q   = cfg_data;
                    hc22_pkg::CFG_MODE:  decrypt_q = cfg_data[0];
                    default:             ;
                endcase
            end

            fail_count      <= mismatches;
            pending_count   <= pending_letter_pairs.size();
            results_checked <= compared;
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the 2x2 hill cipher core with directed and random letter pairs under
// many key settings in both modes; a checker beside the core predicts and
// compares every result, this module makes the stimulus and gives the verdict
// ----------------------------------------------------------------------------
module testbench;

    localparam int          CLK_PERIOD      = 10;
    localparam int          LETTER_COUNT    = 26;
    localparam int          RANDOM_PHASES   = 27;
    localparam int          PAIRS_PER_PHASE = 50;
    localparam int unsigned CYCLE_LIMIT     = 100000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // every core input starts at a known value
    logic                            start     = 1'b0;
    hc22_pkg::in_item_t              item      = '0;
    logic                            cfg_valid = 1'b0;
    logic [hc22_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hc22_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                busy;
    hc22_pkg::out_item_t result;
    logic                done;
    logic                cfg_ready;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned results_checked;

    int unsigned cycle_count = 0;
    int unsigned pairs_sent  = 0;
    int unsigned key_loads   = 0;

    // cleared during the middle stretch of the random part that runs with no gaps
    bit idle_enable = 1'b1;

    always #(CLK_PERIOD / 2) clk = ~clk;

    hill_cipher_2x2_mod26_top DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .busy       (busy),
        .result     (result),
        .done       (done),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    hill_pair_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .item            (item),
        .busy            (busy),
        .result          (result),
        .done            (done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .results_checked (results_checked)
    );

    // watchdog, far above the slowest correct run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // mostly legal letter codes, now and then one of the codes 26..31
    function automatic hc22_pkg::letter_t rand_code();
        hc22_pkg::letter_t r;
        if ($urandom_range(0, 99) < 10)
            r = hc22_pkg::letter_t'($urandom_range(26, 31));
        else
            r = hc22_pkg::letter_t'($urandom_range(0, 25));
        return r;
    endfunction

    // one config transaction; returns at the accepting edge with valid still
    // high so back-to-back writes need no dead cycle
    task automatic write_reg(input logic [hc22_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hc22_pkg::CFG_DATA_W-1:0] val);
        if (idle_enable && $urandom_range(0, 99) < 9)
        begin
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // full key load, sometimes followed by a write to an unused index
    task automatic load_key(input hc22_pkg::letter_t ka, input hc22_pkg::letter_t kb,
                            input hc22_pkg::letter_t kc, input hc22_pkg::letter_t kd,
                            input logic mode);
        write_reg(hc22_pkg::CFG_KEY_A, ka);
        write_reg(hc22_pkg::CFG_KEY_B, kb);
        write_reg(hc22_pkg::CFG_KEY_C, kc);
        write_reg(hc22_pkg::CFG_KEY_D, kd);
        write_reg(hc22_pkg::CFG_MODE, {4'd0, mode});
        if ($urandom_range(0, 4) == 0)
            write_reg(hc22_pkg::CFG_MODE + 3'($urandom_range(1, 3)), 5'($urandom));
        cfg_valid <= 1'b0;
        key_loads++;
    endtask

    // one command transaction; start stays high into the next pair unless
    // a random gap is taken
    task automatic send_pair(input hc22_pkg::letter_t first, input hc22_pkg::letter_t second,
                             input logic present);
        hc22_pkg::in_item_t pair;
        pair.first_letter   = first;
        pair.second_letter  = second;
        pair.second_present = present;
        if (idle_enable && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= pair;
        @(posedge clk);
        while (busy) @(posedge clk);
        pairs_sent++;
    endtask

    // stop sending and wait until every predicted pair has come back
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    initial
    begin
        int                phase;
        int                tries;
        int                det;
        bit                want_invertible;
        hc22_pkg::letter_t ka, kb, kc, kd;

        // reset held once, at the start
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key is the identity in encrypt mode
        send_pair(5'd0, 5'd0, 1'b1);
        send_pair(5'd25, 5'd25, 1'b1);
        send_pair(5'd31, 5'd26, 1'b1);      // codes above 25 wrap
        send_pair(5'd7, 5'd19, 1'b0);       // missing second letter pads with 0
        send_pair(5'd26, 5'd31, 1'b0);
        drain();

        // invertible key, determinant 9
        load_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b0);
        send_pair(5'd7, 5'd4, 1'b1);
        send_pair(5'd25, 5'd0, 1'b1);
        send_pair(5'd0, 5'd25, 1'b1);
        send_pair(5'd11, 5'd30, 1'b0);
        drain();

        // same key in decrypt mode
        load_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b1);
        send_pair(5'd7, 5'd8, 1'b1);
        send_pair(5'd25, 5'd25, 1'b1);
        send_pair(5'd28, 5'd29, 1'b1);
        drain();

        // key codes above 25, decrypt
        load_key(5'd31, 5'd0, 5'd0, 5'd27, 1'b1);
        send_pair(5'd13, 5'd17, 1'b1);
        send_pair(5'd30, 5'd5, 1'b0);
        drain();

        // even determinant, key error in both modes
        load_key(5'd2, 5'd4, 5'd6, 5'd8, 1'b0);
        send_pair(5'd5, 5'd5, 1'b1);
        send_pair(5'd25, 5'd25, 1'b0);
        drain();
        write_reg(hc22_pkg::CFG_MODE, 5'd1);
        cfg_valid <= 1'b0;
        send_pair(5'd1, 5'd2, 1'b1);
        drain();

        // zero determinant via code 26, then determinant 13
        load_key(5'd26, 5'd0, 5'd0, 5'd26, 1'b0);
        send_pair(5'd12, 5'd13, 1'b1);
        drain();
        load_key(5'd13, 5'd0, 5'd0, 5'd1, 1'b1);
        send_pair(5'd1, 5'd1, 1'b1);
        drain();

        // writes to unused indexes must leave the key alone
        load_key(5'd1, 5'd1, 5'd0, 5'd1, 1'b0);
        write_reg(hc22_pkg::CFG_MODE + 3'd1, 5'd31);
        write_reg(hc22_pkg::CFG_MODE + 3'd2, 5'd0);
        write_reg(hc22_pkg::CFG_MODE + 3'd3, 5'd21);
        cfg_valid <= 1'b0;
        send_pair(5'd24, 5'd3, 1'b1);
        send_pair(5'd3, 5'd24, 1'b1);
        drain();

        // random part: a fresh key per phase, mostly invertible so the
        // matrix path is exercised; a middle stretch runs with no gaps
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_enable     = !(phase >= 8 && phase < 14);
            want_invertible = ($urandom_range(0, 99) < 80);
            tries = 0;
            do
            begin
                ka = rand_code();
                kb = rand_code();
                kc = rand_code();
                kd = rand_code();
                det = (int'(ka) % LETTER_COUNT) * (int'(kd) % LETTER_COUNT)
                    + LETTER_COUNT * LETTER_COUNT
                    - (int'(kb) % LETTER_COUNT) * (int'(kc) % LETTER_COUNT);
                det = det % LETTER_COUNT;
                tries++;
            end
            while (want_invertible && (det % 2 == 0 || det == 13) && tries < 20);
            load_key(ka, kb, kc, kd, 1'($urandom_range(0, 1)));
            repeat (PAIRS_PER_PHASE)
                send_pair(rand_code(), rand_code(), ($urandom_range(0, 99) < 75));
            drain();
        end

        // let the pipeline settle past its latency
        repeat (8) @(posedge clk);

        $display("summary: %0d letter pairs under %0d key loads, %0d results compared",
                 pairs_sent, key_loads, results_checked);
        $display("summary: both modes, singular keys, padded pairs, codes 26..31 and unused indexes");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
